/* rtl/lpg_pkg.sv */
`default_nettype none

package lpg_pkg;

    // Timing of the LED patterns.
    localparam int PWM_STEPS             = 100;
    localparam int BREATHE_PERIOD_MS     = 2000;
    localparam int FAULT_PERIOD_MS       = 500;
    localparam int INPUT_BLINK_PERIOD_MS = 1000;
    localparam int TICKS_PER_MS          = 10;

    // Energy scaling and blink duty divisors.
    localparam int PCT_FULL      = 100;
    localparam int PCT_ROUND     = 50;
    localparam int TEST_DUTY_DIV = 5;
    localparam int CHG_DUTY_DIV  = 2;
    localparam int PCT_W         = 8;

    // Counter widths.
    localparam int PWM_W = $clog2(PWM_STEPS);
    localparam int SUB_W = (TICKS_PER_MS > 1) ? $clog2(TICKS_PER_MS) : 1;
    localparam int BR_W  = $clog2(BREATHE_PERIOD_MS);
    localparam int FLT_W = $clog2(FAULT_PERIOD_MS);
    localparam int BLK_W = $clog2(INPUT_BLINK_PERIOD_MS);
    localparam int PSAT_W = $clog2(PCT_FULL + 1);

    // Value ranges of the breathing ramp arithmetic.
    localparam int BR_HALF  = BREATHE_PERIOD_MS / 2;
    localparam int DIST_MAX = (BREATHE_PERIOD_MS - BR_HALF - 1 > BR_HALF) ?
                              (BREATHE_PERIOD_MS - BR_HALF - 1) : BR_HALF;
    localparam int DIST_W   = $clog2(DIST_MAX + 1);
    localparam int X1_MAX   = DIST_MAX * PWM_STEPS;
    localparam int X1_W     = $clog2(X1_MAX + 1);
    localparam int LVL_MAX  = X1_MAX / BR_HALF;
    localparam int LVL_W    = $clog2(LVL_MAX + 1);
    localparam int SQ_MAX   = LVL_MAX * LVL_MAX + PWM_STEPS / 2;
    localparam int SQ_W     = $clog2(SQ_MAX + 1);
    localparam int DUTY_MAX = SQ_MAX / PWM_STEPS;
    localparam int DUTY_W   = $clog2(DUTY_MAX + 1);
    localparam int X3_MAX   = DUTY_MAX * PCT_FULL + PCT_ROUND;
    localparam int X3_W     = $clog2(X3_MAX + 1);
    localparam int SCL_MAX  = X3_MAX / PCT_FULL;
    localparam int SCL_W    = $clog2(SCL_MAX + 1);
    localparam int CMP_W0   = (PWM_W > DUTY_W) ? PWM_W : DUTY_W;
    localparam int CMP_W    = (CMP_W0 > SCL_W) ? CMP_W0 : SCL_W;

    // Reciprocal multipliers for the three constant divisions. With the shift
    // equal to the dividend width plus the divisor's log2, the rounded-up
    // reciprocal gives the exact truncated quotient for every dividend.
    localparam int    SH1    = X1_W + $clog2(BR_HALF);
    localparam longint MUL1  = ((longint'(1) << SH1) + BR_HALF - 1) / BR_HALF;
    localparam int    MUL1_W = $clog2(MUL1 + 1);
    localparam int    SH2    = SQ_W + $clog2(PWM_STEPS);
    localparam longint MUL2  = ((longint'(1) << SH2) + PWM_STEPS - 1) / PWM_STEPS;
    localparam int    MUL2_W = $clog2(MUL2 + 1);
    localparam int    SH3    = X3_W + $clog2(PCT_FULL);
    localparam longint MUL3  = ((longint'(1) << SH3) + PCT_FULL - 1) / PCT_FULL;
    localparam int    MUL3_W = $clog2(MUL3 + 1);

    typedef logic [PCT_W-1:0]         pct_t;
    typedef logic [PWM_W-1:0]         pwm_t;
    typedef logic [SUB_W-1:0]         sub_t;
    typedef logic [BR_W-1:0]          br_phase_t;
    typedef logic [FLT_W-1:0]         flt_phase_t;
    typedef logic [BLK_W-1:0]         blk_phase_t;
    typedef logic [PSAT_W-1:0]        pct_sat_t;
    typedef logic [DIST_W-1:0]        dist_t;
    typedef logic [X1_W-1:0]          x1_t;
    typedef logic [LVL_W-1:0]         lvl_t;
    typedef logic [SQ_W-1:0]          sq_t;
    typedef logic [DUTY_W-1:0]        duty_t;
    typedef logic [X3_W-1:0]          x3_t;
    typedef logic [SCL_W-1:0]         scl_t;
    typedef logic [CMP_W-1:0]         cmp_t;
    typedef logic [X1_W+MUL1_W-1:0]   prod1_t;
    typedef logic [SQ_W+MUL2_W-1:0]   prod2_t;
    typedef logic [X3_W+MUL3_W-1:0]   prod3_t;

    // One PWM tick as it arrives on the input channel.
    typedef struct packed {
        logic fault_flag;
        logic input_ok;
        logic charging;
        logic test_mode;
        pct_t energy_pct;
    } tick_item_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic adv;
        logic ld_level;
        logic ld_sq;
        logic ld_duty;
        logic ld_x3;
        logic ld_out;
    } ctrl_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

/* rtl/lpg_tick_if.sv */
`default_nettype none

interface lpg_tick_if;
    logic                      valid;
    logic                      ready;
    logic                      fault_flag;
    logic                      input_ok;
    logic                      charging;
    logic                      test_mode;
    logic [lpg_pkg::PCT_W-1:0] energy_pct;

    modport source (
        output valid, fault_flag, input_ok, charging, test_mode, energy_pct,
        input  ready
    );

    modport sink (
        input  valid, fault_flag, input_ok, charging, test_mode, energy_pct,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/lpg_led_if.sv */
`default_nettype none

interface lpg_led_if;
    logic valid;
    logic ready;
    logic sys_led_on;
    logic input_led_on;
    logic energy_led_on;

    modport source (
        output valid, sys_led_on, input_led_on, energy_led_on,
        input  ready
    );

    modport sink (
        input  valid, sys_led_on, input_led_on, energy_led_on,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/led_pattern_pwm_generator_core.sv */
// LED pattern PWM generator core.
// The tick channel carries one PWM timer tick per transaction, with the fault,
// input-valid, charging and manual-test flags and the supercap energy percent.
// Each accepted tick advances the PWM step, the sub-millisecond prescaler and
// the millisecond phase counters, and yields exactly one transaction on the led
// channel with the lit state of the system, input and energy LEDs.
// The controller walks the breathing arithmetic one multiply per cycle (level,
// square, gamma divide, energy scale, final divide and compare), the last step
// waiting for a free output register, and takes no new tick until it is done.
// A finished result waits in the output register while the next tick is taken.
// If the led receiver stalls, the next result is held in the datapath until the
// output register frees, and no further tick is accepted until then.
// Reset clears all phase counters to zero, empties the output register and
// leaves the block ready for a tick; there is no configuration.

`default_nettype none

module led_pattern_pwm_generator_core (
    input  wire logic  clk,
    input  wire logic  rst_n,
    lpg_tick_if.sink   tick,
    lpg_led_if.source  led
);

    lpg_pkg::tick_item_t item;
    lpg_pkg::ctrl_cmd_t  cmd;
    lpg_pkg::dp_status_t sts;

    // Payload of the tick transaction, handed to the datapath as one word.
    assign item.fault_flag = tick.fault_flag;
    assign item.input_ok   = tick.input_ok;
    assign item.charging   = tick.charging;
    assign item.test_mode  = tick.test_mode;
    assign item.energy_pct = tick.energy_pct;

    // The controller owns the tick handshake and sequences the datapath.
    lpg_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (tick.valid),
        .tick_ready (tick.ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    // The datapath holds the counters, the arithmetic and the output register.
    lpg_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .sts   (sts),
        .item  (item),
        .led   (led)
    );

endmodule

`default_nettype wire

/* rtl/lpg_datapath.sv */
`default_nettype none

module lpg_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  lpg_pkg::ctrl_cmd_t      cmd,
    output lpg_pkg::dp_status_t     sts,
    input  lpg_pkg::tick_item_t     item,
    lpg_led_if.source               led
);

    // Phase counters.
    lpg_pkg::pwm_t       pwm_step_reg, pwm_step_next;
    lpg_pkg::sub_t       subtick_reg, subtick_next;
    lpg_pkg::br_phase_t  breathe_phase_reg, breathe_phase_next;
    lpg_pkg::flt_phase_t fault_phase_reg, fault_phase_next;
    lpg_pkg::blk_phase_t blink_phase_reg, blink_phase_next;
    logic                ms_tick;

    // Latched tick flags.
    logic                fault_reg, valid_reg, chg_reg, test_reg, pct_zero_reg;
    lpg_pkg::pct_sat_t   pct_sat_reg, pct_sat_next;

    // Arithmetic pipeline registers and their wires.
    lpg_pkg::dist_t      ramp_dist;
    lpg_pkg::x1_t        x1_reg, x1_next;
    lpg_pkg::prod1_t     prod1;
    lpg_pkg::lvl_t       level_reg, level_next;
    lpg_pkg::sq_t        sq_reg, sq_next;
    lpg_pkg::prod2_t     prod2;
    lpg_pkg::duty_t      duty_reg, duty_next;
    lpg_pkg::x3_t        x3_reg, x3_next;
    lpg_pkg::prod3_t     prod3;
    lpg_pkg::scl_t       scaled;

    // Result register.
    logic                out_valid_reg, out_valid_next;
    logic                sys_reg, sys_next;
    logic                inp_reg, inp_next;
    logic                en_reg, en_next;

    always_comb
    begin
        pwm_step_next      = pwm_step_reg;
        subtick_next       = subtick_reg;
        breathe_phase_next = breathe_phase_reg;
        fault_phase_next   = fault_phase_reg;
        blink_phase_next   = blink_phase_reg;
        ms_tick            = (subtick_reg == lpg_pkg::sub_t'(lpg_pkg::TICKS_PER_MS - 1));
        if (cmd.adv)
        begin
            pwm_step_next = (pwm_step_reg == lpg_pkg::pwm_t'(lpg_pkg::PWM_STEPS - 1)) ?
                            '0 : pwm_step_reg + lpg_pkg::pwm_t'(1);
            subtick_next  = ms_tick ? '0 : subtick_reg + lpg_pkg::sub_t'(1);
            if (ms_tick)
            begin
                breathe_phase_next = (breathe_phase_reg ==
                    lpg_pkg::br_phase_t'(lpg_pkg::BREATHE_PERIOD_MS - 1)) ?
                    '0 : breathe_phase_reg + lpg_pkg::br_phase_t'(1);
                fault_phase_next = (fault_phase_reg ==
                    lpg_pkg::flt_phase_t'(lpg_pkg::FAULT_PERIOD_MS - 1)) ?
                    '0 : fault_phase_reg + lpg_pkg::flt_phase_t'(1);
                blink_phase_next = (blink_phase_reg ==
                    lpg_pkg::blk_phase_t'(lpg_pkg::INPUT_BLINK_PERIOD_MS - 1)) ?
                    '0 : blink_phase_reg + lpg_pkg::blk_phase_t'(1);
            end
        end
    end

    // Triangle distance from the advanced breathe phase, then scaled by the step count.
    always_comb
    begin
        if (breathe_phase_next <= lpg_pkg::br_phase_t'(lpg_pkg::BR_HALF))
        begin
            ramp_dist = lpg_pkg::dist_t'(breathe_phase_next);
        end
        else
        begin
            ramp_dist = lpg_pkg::dist_t'(lpg_pkg::br_phase_t'(lpg_pkg::BREATHE_PERIOD_MS)
                                         - breathe_phase_next);
        end
        x1_next = lpg_pkg::x1_t'(ramp_dist) * lpg_pkg::x1_t'(lpg_pkg::PWM_STEPS);
    end

    assign pct_sat_next = (item.energy_pct > lpg_pkg::pct_t'(lpg_pkg::PCT_FULL)) ?
                          lpg_pkg::pct_sat_t'(lpg_pkg::PCT_FULL) :
                          lpg_pkg::pct_sat_t'(item.energy_pct);

    // Constant divisions as reciprocal multiplies; the first two load their own registers, the third feeds the compare.
    assign prod1      = lpg_pkg::prod1_t'(x1_reg) * lpg_pkg::prod1_t'(lpg_pkg::MUL1);
    assign level_next = lpg_pkg::lvl_t'(prod1 >> lpg_pkg::SH1);
    assign sq_next    = lpg_pkg::sq_t'(level_reg) * lpg_pkg::sq_t'(level_reg)
                      + lpg_pkg::sq_t'(lpg_pkg::PWM_STEPS / 2);
    assign prod2      = lpg_pkg::prod2_t'(sq_reg) * lpg_pkg::prod2_t'(lpg_pkg::MUL2);
    assign duty_next  = lpg_pkg::duty_t'(prod2 >> lpg_pkg::SH2);
    assign x3_next    = lpg_pkg::x3_t'(duty_reg) * lpg_pkg::x3_t'(pct_sat_reg)
                      + lpg_pkg::x3_t'(lpg_pkg::PCT_ROUND);
    assign prod3      = lpg_pkg::prod3_t'(x3_reg) * lpg_pkg::prod3_t'(lpg_pkg::MUL3);
    assign scaled     = lpg_pkg::scl_t'(prod3 >> lpg_pkg::SH3);

    always_comb
    begin
        if (fault_reg)
        begin
            sys_next = (fault_phase_reg <
                        lpg_pkg::flt_phase_t'(lpg_pkg::FAULT_PERIOD_MS / 2));
        end
        else
        begin
            sys_next = (lpg_pkg::cmp_t'(pwm_step_reg) < lpg_pkg::cmp_t'(duty_reg));
        end

        priority if (!valid_reg)
        begin
            inp_next = 1'b0;
        end
        else if (test_reg)
        begin
            inp_next = (blink_phase_reg < lpg_pkg::blk_phase_t'(
                        lpg_pkg::INPUT_BLINK_PERIOD_MS / lpg_pkg::TEST_DUTY_DIV));
        end
        else if (chg_reg)
        begin
            inp_next = (blink_phase_reg < lpg_pkg::blk_phase_t'(
                        lpg_pkg::INPUT_BLINK_PERIOD_MS / lpg_pkg::CHG_DUTY_DIV));
        end
        else
        begin
            inp_next = 1'b1;
        end

        en_next = !pct_zero_reg &&
                  (lpg_pkg::cmp_t'(pwm_step_reg) < lpg_pkg::cmp_t'(scaled));
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.ld_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (led.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign sts.out_free = !out_valid_reg || led.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwm_step_reg      <= '0;
            subtick_reg       <= '0;
            breathe_phase_reg <= '0;
            fault_phase_reg   <= '0;
            blink_phase_reg   <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            pwm_step_reg      <= pwm_step_next;
            subtick_reg       <= subtick_next;
            breathe_phase_reg <= breathe_phase_next;
            fault_phase_reg   <= fault_phase_next;
            blink_phase_reg   <= blink_phase_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.adv)
        begin
            fault_reg    <= item.fault_flag;
            valid_reg    <= item.input_ok;
            chg_reg      <= item.charging;
            test_reg     <= item.test_mode;
            pct_zero_reg <= (item.energy_pct == '0);
            pct_sat_reg  <= pct_sat_next;
            x1_reg       <= x1_next;
        end
        if (cmd.ld_level)
        begin
            level_reg <= level_next;
        end
        if (cmd.ld_sq)
        begin
            sq_reg <= sq_next;
        end
        if (cmd.ld_duty)
        begin
            duty_reg <= duty_next;
        end
        if (cmd.ld_x3)
        begin
            x3_reg <= x3_next;
        end
        if (cmd.ld_out)
        begin
            sys_reg <= sys_next;
            inp_reg <= inp_next;
            en_reg  <= en_next;
        end
    end

    assign led.valid         = out_valid_reg;
    assign led.sys_led_on    = sys_reg;
    assign led.input_led_on  = inp_reg;
    assign led.energy_led_on = en_reg;

endmodule

`default_nettype wire

/* rtl/lpg_ctrl.sv */
`default_nettype none

module lpg_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           tick_valid,
    output logic                tick_ready,
    input  lpg_pkg::dp_status_t sts,
    output lpg_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEVEL,
        S_SQUARE,
        S_DUTY,
        S_SCALE,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (tick_valid && ready_reg)
                begin
                    cmd.adv    = 1'b1;
                    state_next = S_LEVEL;
                end
            end
            S_LEVEL:
            begin
                cmd.ld_level = 1'b1;
                state_next   = S_SQUARE;
            end
            S_SQUARE:
            begin
                cmd.ld_sq  = 1'b1;
                state_next = S_DUTY;
            end
            S_DUTY:
            begin
                cmd.ld_duty = 1'b1;
                state_next  = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.ld_x3  = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.ld_out = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        ready_next = (state_next == S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign tick_ready = ready_reg;

    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg |-> (state_reg == S_IDLE))
        else $error("ready raised outside idle");

    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command in a cycle");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_valid && ready_reg) |=> (state_reg == S_LEVEL) && !ready_reg)
        else $error("accepted transaction did not start the sequence");

    a_finish_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && !sts.out_free) |=> (state_reg == S_FINISH))
        else $error("result dropped while the output register was full");

endmodule

`default_nettype wire
